/* rtl/msh_pkg.sv */
// Shared types and constants for the moving average hysteresis switch.
package msh_pkg;

    localparam int DATA_W         = 12;
    localparam int WINDOW_DEFAULT = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int TDATA_IN_W     = 16;
    localparam int TDATA_OUT_W    = 16;

    localparam logic [DATA_W-1:0] ON_THRESHOLD_RESET  = 12'd2000;
    localparam logic [DATA_W-1:0] OFF_THRESHOLD_RESET = 12'd2500;

    localparam logic [CFG_IDX_W-1:0] REG_ON_THRESHOLD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

/* rtl/moving_average_hysteresis_switch.sv */
// Sliding-window mean of a sensor sample stream driving a hysteresis switch.
// An accepted beat passes through the UPDATE, DIV and DONE states before the result
// beat is offered; a new sample is taken only in IDLE, once the last one is through.
// The bit-serial divider in DIV retires one quotient bit per cycle.
// Reset clears the fill count, write slot, running sum and switch (off) and loads
// the threshold defaults; the sample ring needs no clearing.
module moving_average_hysteresis_switch #(
    parameter int WINDOW = msh_pkg::WINDOW_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [msh_pkg::TDATA_IN_W-1:0]  s_tdata,   // [11:0] sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [msh_pkg::TDATA_OUT_W-1:0] m_tdata,   // [11:0] average, [12] switch_on
    input  logic                            cfg_we,
    input  logic [msh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msh_pkg::DATA_W-1:0]      cfg_data
);

    localparam int DATA_W = msh_pkg::DATA_W;
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = DATA_W + $clog2(WINDOW);

    msh_pkg::state_t state_reg, state_next;

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              switch_reg, switch_next;
    logic [DATA_W-1:0] on_thr_reg, off_thr_reg;
    logic [DATA_W-1:0] sample_reg;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] avg_reg, avg_next;
    logic              out_switch_reg, out_switch_next;

    logic              accept;
    logic              ram_we;
    logic [DATA_W-1:0] old_sample;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] quotient;

    assign s_tready = (state_reg == msh_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    msh_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (slot_reg),
        .wr_data (sample_reg),
        .rd_en   (accept),
        .rd_addr (slot_reg),
        .rd_data (old_sample)
    );

    msh_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        switch_next     = switch_reg;
        m_valid_next    = m_valid_reg;
        avg_next        = avg_reg;
        out_switch_next = out_switch_reg;
        ram_we          = 1'b0;
        div_start       = 1'b0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            msh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = msh_pkg::ST_UPDATE;
                end
            end
            msh_pkg::ST_UPDATE:
            begin
                // The slot's old sample was read on the accepting edge; now overwrite it.
                ram_we    = 1'b1;
                div_start = 1'b1;
                if (count_reg == CNT_W'(WINDOW))
                begin
                    sum_next = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
                end
                else
                begin
                    sum_next   = sum_reg + SUM_W'(sample_reg);
                    count_next = count_reg + 1'b1;
                end
                slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                state_next = msh_pkg::ST_DIV;
            end
            msh_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = msh_pkg::ST_DONE;
                end
            end
            msh_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    // The off test wins when the thresholds are crossed.
                    if (quotient > off_thr_reg)
                    begin
                        switch_next = 1'b0;
                    end
                    else if (quotient < on_thr_reg)
                    begin
                        switch_next = 1'b1;
                    end
                    avg_next        = quotient;
                    out_switch_next = switch_next;
                    m_valid_next    = 1'b1;
                    state_next      = msh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msh_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            switch_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            on_thr_reg  <= msh_pkg::ON_THRESHOLD_RESET;
            off_thr_reg <= msh_pkg::OFF_THRESHOLD_RESET;
        end
        else
        begin
            slot_reg    <= slot_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            switch_reg  <= switch_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    msh_pkg::REG_ON_THRESHOLD:  on_thr_reg  <= cfg_data;
                    msh_pkg::REG_OFF_THRESHOLD: off_thr_reg <= cfg_data;
                    default:                    on_thr_reg  <= on_thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= s_tdata[DATA_W-1:0];
        end
        avg_reg        <= avg_next;
        out_switch_reg <= out_switch_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(msh_pkg::TDATA_OUT_W - DATA_W - 1){1'b0}}, out_switch_reg, avg_reg};

endmodule

/* rtl/msh_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module msh_ram #(
    parameter int WIDTH = msh_pkg::DATA_W,
    parameter int DEPTH = msh_pkg::WINDOW_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/msh_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module msh_div #(
    parameter int SUM_W = msh_pkg::DATA_W + 4,
    parameter int CNT_W = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [SUM_W-1:0]          dividend,
    input  logic [CNT_W-1:0]          divisor,
    output logic                      done,
    output logic [msh_pkg::DATA_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        diff      = trial - {1'b0, div_reg};
        ge        = (trial >= {1'b0, div_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SUM_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The dividend shifts out of the top while quotient bits enter at the bottom.
            quo_next = {quo_reg[SUM_W-2:0], ge};
            rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[msh_pkg::DATA_W-1:0];

endmodule
